// File: hw/rtl/wpu_pkg.sv
// shared types and constants of the window pooling unit
// field widths, register indexes, request and mode codes, configuration struct
// no dependencies
package wpu_pkg;

	localparam int DATA_W     = 16;
	localparam int CH_W       = 4;
	localparam int IDX_W      = 5;
	localparam int STEP_W     = 3;
	localparam int BASE_W     = IDX_W + STEP_W;
	localparam int POS_W      = BASE_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_CHANNELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_ROWS  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RESULT_COLS  = 3'd7;

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;
	localparam logic MODE_MAX    = 1'b0;
	localparam logic MODE_AVG    = 1'b1;

	localparam logic signed [DATA_W-1:0] OUTSIDE_VALUE = 16'sh8000;

	typedef struct packed {
		logic       pool_mode;
		logic [2:0] window_size;
		logic [2:0] step_size;
		logic [4:0] map_channels;
		logic [5:0] map_rows;
		logic [5:0] map_cols;
		logic [5:0] result_rows;
		logic [5:0] result_cols;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		pool_mode:    MODE_MAX,
		window_size:  3'd2,
		step_size:    3'd2,
		map_channels: 5'd1,
		map_rows:     6'd32,
		map_cols:     6'd32,
		result_rows:  6'd16,
		result_cols:  6'd16
	};

endpackage

// File: hw/rtl/wpu_store.sv
// feature map storage: single-port-write, single-port-read synchronous ram
// read data registered, valid in the cycle after the read enable
// depends on wpu_pkg for the sample width
module wpu_store #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [ADDR_W-1:0]                 wr_addr,
	input  logic signed [wpu_pkg::DATA_W-1:0] wr_data,
	input  logic                              rd_en,
	input  logic [ADDR_W-1:0]                 rd_addr,
	output logic signed [wpu_pkg::DATA_W-1:0] rd_data
);
	import wpu_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/wpu_div.sv
// signed divide by a small unsigned divisor, truncating toward zero
// restoring divide on the magnitude, two quotient bits per cycle
// depends on wpu_pkg for the quotient width
module wpu_div #(
	parameter int ACC_W = 20,
	parameter int DVS_W = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [ACC_W-1:0]           dividend,
	input  logic [DVS_W-1:0]                  divisor,
	output logic                              done,
	output logic signed [wpu_pkg::DATA_W-1:0] quotient
);
	import wpu_pkg::*;

	localparam int NCYC  = (ACC_W + 1) / 2;
	localparam int PAD_W = 2 * NCYC;
	localparam int CNT_W = $clog2(NCYC);

	logic                     busy_q;
	logic                     done_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [PAD_W-1:0]         num_q;
	logic [DVS_W-1:0]         rem_q;
	logic [DVS_W-1:0]         dvs_q;
	logic                     neg_q;
	logic signed [DATA_W-1:0] quo_q;

	logic [ACC_W-1:0] mag;
	logic [PAD_W-1:0] num_n;
	logic [DVS_W-1:0] rem_n;
	logic [DVS_W:0]   trial;
	logic [PAD_W-1:0] q_fin;
	logic             last;

	assign mag  = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
	assign last = (cnt_q == CNT_W'(NCYC - 1));

	// two restoring steps; dividend shifts out the top while quotient bits enter below
	always_comb begin
		num_n = num_q;
		rem_n = rem_q;
		trial = '0;
		for (int k = 0; k < 2; k++) begin
			trial = {rem_n, num_n[PAD_W-1]};
			num_n = num_n << 1;
			if (trial >= {1'b0, dvs_q}) begin
				rem_n    = DVS_W'(trial - {1'b0, dvs_q});
				num_n[0] = 1'b1;
			end else begin
				rem_n = DVS_W'(trial);
			end
		end
		q_fin = neg_q ? -num_n : num_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PAD_W'(mag);
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[ACC_W-1];
		end else if (busy_q) begin
			num_q <= num_n;
			rem_q <= rem_n;
			if (last) begin
				quo_q <= $signed(q_fin[DATA_W-1:0]);
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divide started while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divide done held longer than one cycle");

endmodule

// File: hw/rtl/wpu_ctrl.sv
// request decode and window sequencer: store writes, window scan reads,
// max / sum accumulation, divider hand-off and the result register
// depends on wpu_pkg
module wpu_ctrl #(
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_ROWS     = 32,
	parameter int MAX_COLS     = 32,
	parameter int MAX_WINDOW   = 4,
	parameter int ADDR_W       = 14,
	parameter int ACC_W        = 20,
	parameter int WN_W         = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wpu_pkg::cfg_t                     cfg,
	input  logic                              start,
	output logic                              busy,
	input  logic                              req_type,
	input  logic [wpu_pkg::CH_W-1:0]          chan,
	input  logic [wpu_pkg::IDX_W-1:0]         row_index,
	input  logic [wpu_pkg::IDX_W-1:0]         col_index,
	input  logic signed [wpu_pkg::DATA_W-1:0] sample,
	output logic                              wr_en,
	output logic [ADDR_W-1:0]                 wr_addr,
	output logic signed [wpu_pkg::DATA_W-1:0] wr_data,
	output logic                              rd_en,
	output logic [ADDR_W-1:0]                 rd_addr,
	input  logic signed [wpu_pkg::DATA_W-1:0] rd_data,
	output logic                              div_start,
	output logic signed [ACC_W-1:0]           div_dividend,
	output logic [2*WN_W-1:0]                 div_divisor,
	input  logic                              div_done,
	input  logic signed [wpu_pkg::DATA_W-1:0] div_quotient,
	output logic                              done,
	output logic signed [wpu_pkg::DATA_W-1:0] pooled_value,
	output logic                              coord_error
);
	import wpu_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW);
	localparam int SQ_W  = 2 * WN_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	logic [1:0]               state_q;
	logic [CH_W-1:0]          ch_q;
	logic [BASE_W-1:0]        base_r_q;
	logic [BASE_W-1:0]        base_k_q;
	logic [WN_W-1:0]          win_q;
	logic                     mode_q;
	logic [CNT_W-1:0]         i_q;
	logic [CNT_W-1:0]         j_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     vld_s1;
	logic                     in_s1;
	logic                     last_s1;
	logic                     done_q;
	logic signed [DATA_W-1:0] pooled_q;
	logic                     err_q;

	logic                     accept;
	logic                     ch_ok;
	logic                     load_ok;
	logic                     req_err;
	logic [WN_W-1:0]          win_cfg;
	logic [POS_W-1:0]         pr;
	logic [POS_W-1:0]         pk;
	logic                     in_map;
	logic                     last_i;
	logic                     last_j;
	logic signed [ACC_W-1:0]  v_ext;
	logic signed [ACC_W-1:0]  acc_nxt;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign ch_ok   = (32'(chan) < MAX_CHANNELS) && ({1'b0, chan} < cfg.map_channels);
	assign load_ok = ch_ok
		&& (32'(row_index) < MAX_ROWS) && ({1'b0, row_index} < cfg.map_rows)
		&& (32'(col_index) < MAX_COLS) && ({1'b0, col_index} < cfg.map_cols);
	assign req_err = !ch_ok
		|| ({1'b0, row_index} >= cfg.result_rows)
		|| ({1'b0, col_index} >= cfg.result_cols);

	// window side: zero acts as one, large values clamp to the maximum
	always_comb begin
		if (cfg.window_size == 3'd0) begin
			win_cfg = WN_W'(1);
		end else if (32'(cfg.window_size) > MAX_WINDOW) begin
			win_cfg = WN_W'(MAX_WINDOW);
		end else begin
			win_cfg = WN_W'(cfg.window_size);
		end
	end

	assign wr_en   = accept && (req_type == REQ_LOAD) && load_ok;
	assign wr_addr = ADDR_W'((32'(chan) * MAX_ROWS + 32'(row_index)) * MAX_COLS
		+ 32'(col_index));
	assign wr_data = sample;

	assign pr     = POS_W'(base_r_q) + POS_W'(i_q);
	assign pk     = POS_W'(base_k_q) + POS_W'(j_q);
	assign in_map = (32'(pr) < MAX_ROWS) && (pr < POS_W'(cfg.map_rows))
		&& (32'(pk) < MAX_COLS) && (pk < POS_W'(cfg.map_cols));
	assign last_i = (WN_W'(i_q) == win_q - WN_W'(1));
	assign last_j = (WN_W'(j_q) == win_q - WN_W'(1));

	assign rd_en   = (state_q == ST_SCAN) && in_map;
	assign rd_addr = ADDR_W'((32'(ch_q) * MAX_ROWS + 32'(pr)) * MAX_COLS + 32'(pk));

	// positions off the map count as the most negative sample
	assign v_ext   = in_s1 ? ACC_W'(rd_data) : ACC_W'(OUTSIDE_VALUE);
	assign acc_nxt = (mode_q == MODE_MAX) ? ((v_ext > acc_q) ? v_ext : acc_q)
		: acc_q + v_ext;

	assign div_start    = (state_q == ST_DRAIN) && (mode_q == MODE_AVG);
	assign div_dividend = acc_nxt;
	assign div_divisor  = SQ_W'(win_q) * SQ_W'(win_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req_type == REQ_COMPUTE)) begin
						if (req_err) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
							i_q     <= '0;
							j_q     <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (last_j) begin
						j_q <= '0;
						i_q <= i_q + CNT_W'(1);
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
					if (last_i && last_j) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mode_q == MODE_MAX) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		in_s1   <= in_map;
		last_s1 <= last_i && last_j;
		if (accept) begin
			ch_q     <= chan;
			base_r_q <= BASE_W'(row_index) * BASE_W'(cfg.step_size);
			base_k_q <= BASE_W'(col_index) * BASE_W'(cfg.step_size);
			win_q    <= win_cfg;
			mode_q   <= cfg.pool_mode;
			acc_q    <= (cfg.pool_mode == MODE_MAX) ? ACC_W'(OUTSIDE_VALUE) : '0;
		end else if (vld_s1) begin
			acc_q <= acc_nxt;
		end
		if (accept && (req_type == REQ_COMPUTE) && req_err) begin
			pooled_q <= '0;
			err_q    <= 1'b1;
		end else if ((state_q == ST_DRAIN) && (mode_q == MODE_MAX)) begin
			pooled_q <= DATA_W'(acc_nxt);
			err_q    <= 1'b0;
		end else if ((state_q == ST_DIV) && div_done) begin
			pooled_q <= div_quotient;
			err_q    <= 1'b0;
		end
	end

	assign done         = done_q;
	assign pooled_value = pooled_q;
	assign coord_error  = err_q;

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (vld_s1 && last_s1))
		else $error("drain reached without the last window beat");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store write during window scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe while a request is still in work");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && err_q) |-> (pooled_q == '0))
		else $error("coordinate error with nonzero value");

endmodule

// File: hw/rtl/window_pooling_unit.sv
// window pooling unit: max / average pooling over a stored feature map
// load: no result, busy stays low, so loads go every cycle while no compute is in work
// compute out of range: done strobes with coord_error set in the cycle after the accept
// max mode: window scan (one store read per window position), then drain, then the result
// average mode: scan and drain as for max, then the 2-bit/cycle divider before the result
// async active-low reset restores register defaults; the map itself stays undefined
module window_pooling_unit #(
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_ROWS     = 32,
	parameter int MAX_COLS     = 32,
	parameter int MAX_WINDOW   = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  req_type,
	input  logic [wpu_pkg::CH_W-1:0]              chan,
	input  logic [wpu_pkg::IDX_W-1:0]             row_index,
	input  logic [wpu_pkg::IDX_W-1:0]             col_index,
	input  logic signed [wpu_pkg::DATA_W-1:0]     sample,
	output logic                                  done,
	output logic signed [wpu_pkg::DATA_W-1:0]     pooled_value,
	output logic                                  coord_error,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wpu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [wpu_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import wpu_pkg::*;

	localparam int DEPTH  = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WN_W   = $clog2(MAX_WINDOW + 1);
	localparam int ACC_W  = DATA_W + 2 * $clog2(MAX_WINDOW);

	cfg_t cfg_q;

	logic                     st_wr_en;
	logic [ADDR_W-1:0]        st_wr_addr;
	logic signed [DATA_W-1:0] st_wr_data;
	logic                     st_rd_en;
	logic [ADDR_W-1:0]        st_rd_addr;
	logic signed [DATA_W-1:0] st_rd_data;
	logic                     div_start;
	logic signed [ACC_W-1:0]  div_dividend;
	logic [2*WN_W-1:0]        div_divisor;
	logic                     div_done;
	logic signed [DATA_W-1:0] div_quotient;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POOL_MODE:    cfg_q.pool_mode    <= cfg_data[0];
				REG_WINDOW_SIZE:  cfg_q.window_size  <= cfg_data[2:0];
				REG_STEP_SIZE:    cfg_q.step_size    <= cfg_data[2:0];
				REG_MAP_CHANNELS: cfg_q.map_channels <= cfg_data[4:0];
				REG_MAP_ROWS:     cfg_q.map_rows     <= cfg_data[5:0];
				REG_MAP_COLS:     cfg_q.map_cols     <= cfg_data[5:0];
				REG_RESULT_ROWS:  cfg_q.result_rows  <= cfg_data[5:0];
				REG_RESULT_COLS:  cfg_q.result_cols  <= cfg_data[5:0];
			endcase
		end
	end

	wpu_ctrl #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.MAX_WINDOW  (MAX_WINDOW),
		.ADDR_W      (ADDR_W),
		.ACC_W       (ACC_W),
		.WN_W        (WN_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.chan         (chan),
		.row_index    (row_index),
		.col_index    (col_index),
		.sample       (sample),
		.wr_en        (st_wr_en),
		.wr_addr      (st_wr_addr),
		.wr_data      (st_wr_data),
		.rd_en        (st_rd_en),
		.rd_addr      (st_rd_addr),
		.rd_data      (st_rd_data),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.done         (done),
		.pooled_value (pooled_value),
		.coord_error  (coord_error)
	);

	wpu_store #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(st_wr_addr),
		.wr_data(st_wr_data),
		.rd_en  (st_rd_en),
		.rd_addr(st_rd_addr),
		.rd_data(st_rd_data)
	);

	wpu_div #(
		.ACC_W(ACC_W),
		.DVS_W(2 * WN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quotient)
	);

endmodule
